[design/uav_presence_vote_fusion_unit_macros.svh]
// ----------------------------------------------------------------------------
// uav presence vote fusion: assertion macros
// shared assertion forms, clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef UAV_PRESENCE_VOTE_FUSION_UNIT_MACROS_SVH
`define UAV_PRESENCE_VOTE_FUSION_UNIT_MACROS_SVH

// same-cycle implication
`define UPVF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define UPVF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/upvf_pkg.sv]
// ----------------------------------------------------------------------------
// upvf_pkg
// widths, register codes, reset values and shared types of the vote fusion
// ----------------------------------------------------------------------------
package upvf_pkg;

	localparam int CLS_W   = 4;
	localparam int CONF_W  = 8;
	localparam int CNT_W   = 7;
	localparam int SUM_W   = 14;
	localparam int MASK_W  = 16;
	localparam int LVL_W   = 2;
	localparam int CFG_IDX_W = 4;

	localparam int MAX_WINDOWS = 64;
	localparam int WIN_CAP_I   = (MAX_WINDOWS < 127) ? MAX_WINDOWS : 127;
	localparam logic [CNT_W-1:0] WIN_CAP = CNT_W'(WIN_CAP_I);
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
	localparam logic [CONF_W-1:0] CONF_MAX = {CONF_W{1'b1}};

	// serial divider: one quotient bit per step
	localparam int DIV_STEPS = SUM_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	// register reset values
	localparam logic [CONF_W-1:0] MIN_CONF_RST  = CONF_W'(128);
	localparam logic [CNT_W-1:0]  MIN_WIN_RST   = CNT_W'(3);
	localparam logic [MASK_W-1:0] UAV_MASK_RST  = MASK_W'(7);
	localparam logic [MASK_W-1:0] GND_MASK_RST  = MASK_W'(56);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_CONF = 4'd0,
		REG_MIN_WIN  = 4'd1,
		REG_UAV_MASK = 4'd2,
		REG_GND_MASK = 4'd3
	} cfg_reg_t;

	typedef enum logic [LVL_W-1:0] {
		LVL_NONE      = 2'd0,
		LVL_SUSPECT   = 2'd1,
		LVL_ENGINE    = 2'd2,
		LVL_CONFIRMED = 2'd3
	} level_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_WAIT
	} state_t;

	typedef struct packed {
		logic              start;
		logic [SUM_W-1:0]  dividend;
		logic [CNT_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [SUM_W-1:0]  quotient;
	} div_rsp_t;

	// counts frozen at the closing word
	typedef struct packed {
		logic [CNT_W-1:0]  windows;
		logic [CNT_W-1:0]  uav;
		logic [CNT_W-1:0]  ground;
		logic              gate;
		logic [CONF_W-1:0] gate_score;
	} snap_t;

	typedef struct packed {
		logic [LVL_W-1:0]  presence_level;
		logic [CONF_W-1:0] fused_confidence;
		logic [CNT_W-1:0]  window_total;
		logic [CNT_W-1:0]  uav_count;
		logic [CNT_W-1:0]  ground_count;
		logic              gate_flag;
	} res_t;

endpackage

[design/upvf_if.sv]
// ----------------------------------------------------------------------------
// upvf channel interfaces
// vote input, result output and register write channels, valid/ready each
// ----------------------------------------------------------------------------
interface upvf_vote_if;
	import upvf_pkg::*;

	logic              valid;
	logic              ready;
	logic              vote_present;
	logic [CLS_W-1:0]  class_code;
	logic [CONF_W-1:0] vote_confidence;
	logic              last_vote;
	logic              gate_present;
	logic [CONF_W-1:0] gate_confidence;

	modport source (output valid, vote_present, class_code, vote_confidence, last_vote,
		gate_present, gate_confidence, input ready);
	modport sink (input valid, vote_present, class_code, vote_confidence, last_vote,
		gate_present, gate_confidence, output ready);
endinterface

interface upvf_res_if;
	import upvf_pkg::*;

	logic              valid;
	logic              ready;
	logic [LVL_W-1:0]  presence_level;
	logic [CONF_W-1:0] fused_confidence;
	logic [CNT_W-1:0]  window_total;
	logic [CNT_W-1:0]  uav_count;
	logic [CNT_W-1:0]  ground_count;
	logic              gate_flag;

	modport source (output valid, presence_level, fused_confidence, window_total,
		uav_count, ground_count, gate_flag, input ready);
	modport sink (input valid, presence_level, fused_confidence, window_total,
		uav_count, ground_count, gate_flag, output ready);
endinterface

interface upvf_cfg_if;
	import upvf_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [MASK_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[design/upvf_div.sv]
// ----------------------------------------------------------------------------
// upvf_div
// restoring serial divider, one quotient bit per cycle, for the mean confidence
// ----------------------------------------------------------------------------
module upvf_div (
	input  logic               clk,
	input  logic               arst_n,
	input  upvf_pkg::div_req_t req,
	output upvf_pkg::div_rsp_t rsp
);
	import upvf_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]  rem_q;
	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  dsor_q;

	logic [CNT_W:0]    rem_sh;
	logic              ge;
	logic [CNT_W:0]    diff;
	logic              last_step;

	// quotient bits shift in where dividend bits shift out
	assign rem_sh    = {rem_q, quo_q[SUM_W-1]};
	assign ge        = rem_sh >= {1'b0, dsor_q};
	assign diff      = rem_sh - {1'b0, dsor_q};
	assign last_step = step_q == STEP_W'(DIV_STEPS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && last_step;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= '0;
			quo_q  <= req.dividend;
			dsor_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

[design/upvf_decide.sv]
// ----------------------------------------------------------------------------
// upvf_decide
// presence level and fused confidence from the frozen counts and the mean
// ----------------------------------------------------------------------------
module upvf_decide (
	input  upvf_pkg::snap_t                  snap,
	input  logic [upvf_pkg::SUM_W-1:0]       quotient,
	input  logic [upvf_pkg::CNT_W-1:0]       min_windows,
	output upvf_pkg::res_t                   res
);
	import upvf_pkg::*;

	logic [CONF_W-1:0] mean;
	logic [CNT_W+2:0]  need_x5;
	logic [CNT_W-1:0]  need;
	logic              enough;
	logic              uav_major;
	logic              gnd_major;
	logic              uav_pair;
	logic [CONF_W:0]   avg_sum;
	level_t            level;
	logic [CONF_W-1:0] fused;

	always_comb begin
		// mean is zero with no uav votes, clamped to a byte otherwise
		if (snap.uav == '0) begin
			mean = '0;
		end else if (quotient > SUM_W'(CONF_MAX)) begin
			mean = CONF_MAX;
		end else begin
			mean = quotient[CONF_W-1:0];
		end
	end

	// ceil(5w/8)
	assign need_x5   = {1'b0, snap.windows, 2'b00} + {3'b000, snap.windows} + (CNT_W+3)'(7);
	assign need      = need_x5[CNT_W+2:3];
	assign enough    = snap.windows >= min_windows;
	assign uav_major = enough && (snap.uav >= need);
	assign gnd_major = enough && (snap.ground >= need);
	assign uav_pair  = snap.uav >= CNT_W'(2);
	assign avg_sum   = {1'b0, snap.gate_score} + {1'b0, mean};

	always_comb begin
		priority if (uav_major) begin
			level = LVL_CONFIRMED;
			fused = (snap.gate_score > mean) ? snap.gate_score : mean;
		end else if (snap.gate && gnd_major) begin
			level = LVL_ENGINE;
			fused = snap.gate_score;
		end else if (snap.gate && uav_pair) begin
			level = LVL_CONFIRMED;
			fused = avg_sum[CONF_W:1];
		end else if (snap.gate) begin
			level = LVL_SUSPECT;
			fused = {1'b0, snap.gate_score[CONF_W-1:1]};
		end else if (uav_pair) begin
			level = LVL_SUSPECT;
			fused = {1'b0, mean[CONF_W-1:1]};
		end else begin
			level = LVL_NONE;
			fused = '0;
		end
	end

	assign res.presence_level   = level;
	assign res.fused_confidence = fused;
	assign res.window_total     = snap.windows;
	assign res.uav_count        = snap.uav;
	assign res.ground_count     = snap.ground;
	assign res.gate_flag        = snap.gate;

endmodule

[design/uav_presence_vote_fusion_unit.sv]
// ----------------------------------------------------------------------------
// uav_presence_vote_fusion_unit
// Fuses a set of classifier votes and an acoustic gate outcome into a UAV
// presence level. Each vote word with vote_present set adds a window and,
// if its confidence reaches min_confidence, counts as a UAV vote (summing its
// confidence, saturating at 16383) or as a ground-engine vote, by the class
// masks. Windows beyond 64 are ignored. The word marked last_vote closes the
// set and is the only one whose gate fields are read; after it the counters
// start again from zero. The closing word keeps the input stalled while the
// bit-serial divider forms the mean UAV confidence and until the decision is
// loaded into the output register. Vote words keep flowing while a result
// waits in the output register; a second closing word is still taken, but
// the input then stays stalled until the earlier result has been taken and
// the new one loaded. Registers are written through the cfg channel, which
// is always ready, and are meant to change only while no set is in progress.
// ----------------------------------------------------------------------------
`include "uav_presence_vote_fusion_unit_macros.svh"

module uav_presence_vote_fusion_unit (
	input  logic clk,
	input  logic arst_n,
	upvf_cfg_if.sink    cfg,
	upvf_vote_if.sink   vote,
	upvf_res_if.source  result
);
	import upvf_pkg::*;

	// configuration registers
	logic [CONF_W-1:0] min_conf_q;
	logic [CNT_W-1:0]  min_win_q;
	logic [MASK_W-1:0] uav_mask_q;
	logic [MASK_W-1:0] gnd_mask_q;

	// running counts of the open set
	logic [CNT_W-1:0]  window_cnt_q;
	logic [CNT_W-1:0]  uav_cnt_q;
	logic [CNT_W-1:0]  gnd_cnt_q;
	logic [SUM_W-1:0]  uav_sum_q;

	logic [CNT_W-1:0]  window_cnt_nx;
	logic [CNT_W-1:0]  uav_cnt_nx;
	logic [CNT_W-1:0]  gnd_cnt_nx;
	logic [SUM_W-1:0]  uav_sum_nx;
	logic [SUM_W:0]    sum_wide;

	// frozen counts of the set being decided
	snap_t             snap_q;

	state_t            state_q;
	state_t            state_nx;

	logic              vote_acc;
	logic              close_acc;
	logic              res_load;
	logic              res_free;
	logic              counts;
	logic              qualifies;

	res_t              res_q;
	logic              res_valid_q;
	res_t              res_dec;

	div_req_t          div_req;
	div_rsp_t          div_rsp;

	// ------------------------------------------------------------------
	// register writes, always accepted
	// ------------------------------------------------------------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_conf_q <= MIN_CONF_RST;
			min_win_q  <= MIN_WIN_RST;
			uav_mask_q <= UAV_MASK_RST;
			gnd_mask_q <= GND_MASK_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_MIN_CONF: min_conf_q <= cfg.data[CONF_W-1:0];
				REG_MIN_WIN:  min_win_q  <= cfg.data[CNT_W-1:0];
				REG_UAV_MASK: uav_mask_q <= cfg.data;
				REG_GND_MASK: gnd_mask_q <= cfg.data;
				default: ; // unused indexes are dropped
			endcase
		end
	end

	// ------------------------------------------------------------------
	// vote accumulation
	// ------------------------------------------------------------------
	assign vote_acc  = vote.valid && vote.ready;
	assign close_acc = vote_acc && vote.last_vote;

	// a vote counts as a window only while the window cap is not reached
	assign counts    = vote.vote_present && (window_cnt_q < WIN_CAP);
	assign qualifies = counts && (vote.vote_confidence >= min_conf_q);
	assign sum_wide  = {1'b0, uav_sum_q} + (SUM_W+1)'(vote.vote_confidence);

	always_comb begin
		window_cnt_nx = window_cnt_q;
		uav_cnt_nx    = uav_cnt_q;
		gnd_cnt_nx    = gnd_cnt_q;
		uav_sum_nx    = uav_sum_q;
		if (counts) begin
			window_cnt_nx = window_cnt_q + 1'b1;
		end
		// a class in both masks is taken as uav only
		if (qualifies && uav_mask_q[vote.class_code]) begin
			uav_cnt_nx = uav_cnt_q + 1'b1;
			uav_sum_nx = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
		end else if (qualifies && gnd_mask_q[vote.class_code]) begin
			gnd_cnt_nx = gnd_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_cnt_q <= '0;
			uav_cnt_q    <= '0;
			gnd_cnt_q    <= '0;
			uav_sum_q    <= '0;
		end else if (close_acc) begin
			// set closes: counts move to the snapshot, a fresh set starts
			window_cnt_q <= '0;
			uav_cnt_q    <= '0;
			gnd_cnt_q    <= '0;
			uav_sum_q    <= '0;
		end else if (vote_acc) begin
			window_cnt_q <= window_cnt_nx;
			uav_cnt_q    <= uav_cnt_nx;
			gnd_cnt_q    <= gnd_cnt_nx;
			uav_sum_q    <= uav_sum_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (close_acc) begin
			snap_q.windows    <= window_cnt_nx;
			snap_q.uav        <= uav_cnt_nx;
			snap_q.ground     <= gnd_cnt_nx;
			snap_q.gate       <= vote.gate_present;
			snap_q.gate_score <= vote.gate_present ? vote.gate_confidence : '0;
		end
	end

	// ------------------------------------------------------------------
	// mean confidence through the serial divider
	// ------------------------------------------------------------------
	assign div_req.start    = close_acc;
	assign div_req.dividend = uav_sum_nx;
	assign div_req.divisor  = uav_cnt_nx;

	upvf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	upvf_decide u_decide (
		.snap        (snap_q),
		.quotient    (div_rsp.quotient),
		.min_windows (min_win_q),
		.res         (res_dec)
	);

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	assign res_free = !res_valid_q || result.ready;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (close_acc) begin
					state_nx = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					state_nx = res_free ? ST_IDLE : ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (res_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		vote.ready = 1'b0;
		res_load   = 1'b0;
		unique case (state_q)
			ST_IDLE: vote.ready = 1'b1;
			ST_DIV:  res_load   = div_rsp.done && res_free;
			ST_WAIT: res_load   = res_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// ------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_dec;
		end
	end

	assign result.valid            = res_valid_q;
	assign result.presence_level   = res_q.presence_level;
	assign result.fused_confidence = res_q.fused_confidence;
	assign result.window_total     = res_q.window_total;
	assign result.uav_count        = res_q.uav_count;
	assign result.ground_count     = res_q.ground_count;
	assign result.gate_flag        = res_q.gate_flag;

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	`UPVF_ASSERT_NEXT(a_close_starts_div, close_acc, state_q == ST_DIV, "closing word did not start the divide")
	`UPVF_ASSERT_NOW(a_done_only_in_div, div_rsp.done, state_q == ST_DIV, "divider finished outside the divide state")
	`UPVF_ASSERT_NEXT(a_close_clears, close_acc, window_cnt_q == '0 && uav_cnt_q == '0 && gnd_cnt_q == '0 && uav_sum_q == '0, "counts not cleared after closing word")
	`UPVF_ASSERT_NEXT(a_taken_result_drops, result.valid && result.ready && !res_load, !result.valid, "taken result still shown")

endmodule
